### sv/b64d_pkg.sv
// Shared types, character constants and the symbol map for the base64 stream decoder.
package b64d_pkg;

  localparam int unsigned COUNT_WIDTH_DEFAULT = 16;
  localparam int unsigned BYTE_COUNT_WIDTH    = 16;

  localparam logic [7:0] CHAR_NUL        = 8'h00;
  localparam logic [7:0] CHAR_LF         = 8'h0A;
  localparam logic [7:0] CHAR_CR         = 8'h0D;
  localparam logic [7:0] CHAR_PAD        = 8'h3D;  // '='
  localparam logic [7:0] ALT_PAD_DEFAULT = 8'h24;  // '$'
  localparam logic [7:0] BAD_VALUE       = 8'hFF;

  typedef struct packed {
    logic [7:0]                  data_byte;
    logic                        is_end;
    logic [BYTE_COUNT_WIDTH-1:0] byte_count;
    logic                        bad_char;
  } b64d_result_t;

  // Six-bit symbol value, or BAD_VALUE for anything outside the alphabet.
  function automatic logic [7:0] map_char(input logic [7:0] c);
    logic [7:0] v;
    case (c) inside
      [8'h41:8'h5A]: v = c - 8'd65;   // A-Z
      [8'h61:8'h7A]: v = c - 8'd71;   // a-z
      [8'h30:8'h39]: v = c + 8'd4;    // 0-9
      8'h2B:         v = 8'd62;       // +
      8'h2F:         v = 8'd63;       // /
      default:       v = BAD_VALUE;
    endcase
    return v;
  endfunction

endpackage

### sv/b64d_core.sv
// Group phase tracking, symbol decode and message byte count for the base64 stream decoder.
module b64d_core #(
  parameter int unsigned COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           in_char,
  input  logic [7:0]           alt_pad,
  output logic                 has_result,
  output b64d_pkg::b64d_result_t result
);

  typedef enum logic [2:0] {
    PH_START       = 3'd0,
    PH_AFTER_GROUP = 3'd1,
    PH_AFTER_CR    = 3'd2,
    PH_SECOND      = 3'd3,
    PH_THIRD       = 3'd4,
    PH_FOURTH      = 3'd5
  } phase_t;

  phase_t                 phase, phase_next;
  logic [7:0]             first_value, first_value_next;
  logic [7:0]             second_value, second_value_next;
  logic [7:0]             third_value, third_value_next;
  logic                   third_was_pad, third_was_pad_next;
  logic                   bad_seen, bad_seen_next;
  logic [COUNT_WIDTH-1:0] total, total_next;

  logic [7:0]  sym;
  logic        pad;
  logic        emit;
  logic        emit_bad;
  logic [7:0]  emit_byte;
  logic [31:0] total_wide;

  assign sym        = b64d_pkg::map_char(in_char);
  assign pad        = (in_char == b64d_pkg::CHAR_PAD) || (in_char == alt_pad);
  assign total_wide = 32'(total);

  always_comb begin
    phase_next         = phase;
    first_value_next   = first_value;
    second_value_next  = second_value;
    third_value_next   = third_value;
    third_was_pad_next = third_was_pad;
    bad_seen_next      = bad_seen;
    total_next         = total;
    emit               = 1'b0;
    emit_bad           = 1'b0;
    emit_byte          = '0;
    result             = '0;
    has_result         = 1'b0;

    case (phase)
      PH_SECOND: begin
        second_value_next = sym;
        phase_next        = PH_THIRD;
        emit              = 1'b1;
        emit_byte         = {first_value[5:0], sym[5:4]};
        emit_bad          = (first_value == b64d_pkg::BAD_VALUE) ||
                            (sym == b64d_pkg::BAD_VALUE);
      end
      PH_THIRD: begin
        phase_next = PH_FOURTH;
        if (pad) begin
          third_was_pad_next = 1'b1;
        end else begin
          third_was_pad_next = 1'b0;
          third_value_next   = sym;
          emit               = 1'b1;
          emit_byte          = {second_value[3:0], sym[5:2]};
          emit_bad           = (second_value == b64d_pkg::BAD_VALUE) ||
                               (sym == b64d_pkg::BAD_VALUE);
        end
      end
      PH_FOURTH: begin
        phase_next = PH_AFTER_GROUP;
        if (!third_was_pad && !pad) begin
          emit      = 1'b1;
          emit_byte = {third_value[1:0], 6'd0} | sym;
          emit_bad  = (third_value == b64d_pkg::BAD_VALUE) ||
                      (sym == b64d_pkg::BAD_VALUE);
        end
      end
      default: begin
        // first position of a group, end of message on NUL, with optional CR / CR LF skip after a group
        if (phase == PH_AFTER_GROUP && in_char == b64d_pkg::CHAR_CR) begin
          phase_next = PH_AFTER_CR;
        end else if (phase == PH_AFTER_CR && in_char == b64d_pkg::CHAR_LF) begin
          phase_next = PH_START;
        end else if (in_char == b64d_pkg::CHAR_NUL) begin
          has_result        = 1'b1;
          result.is_end     = 1'b1;
          result.bad_char   = bad_seen;
          result.byte_count = (total_wide > 32'h0000_FFFF) ? '1
                                : total_wide[b64d_pkg::BYTE_COUNT_WIDTH-1:0];
          phase_next         = PH_START;
          first_value_next   = '0;
          second_value_next  = '0;
          third_value_next   = '0;
          third_was_pad_next = 1'b0;
          bad_seen_next      = 1'b0;
          total_next         = '0;
        end else begin
          first_value_next = sym;
          phase_next       = PH_SECOND;
        end
      end
    endcase

    if (emit) begin
      has_result       = 1'b1;
      result.data_byte = emit_byte;
      result.bad_char  = emit_bad;
      if (total != '1) begin
        total_next = total + 1'b1;
      end
      if (emit_bad) begin
        bad_seen_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      first_value   <= '0;
      second_value  <= '0;
      third_value   <= '0;
      third_was_pad <= 1'b0;
      bad_seen      <= 1'b0;
      total         <= '0;
    end else if (take) begin
      phase         <= phase_next;
      first_value   <= first_value_next;
      second_value  <= second_value_next;
      third_value   <= third_value_next;
      third_was_pad <= third_was_pad_next;
      bad_seen      <= bad_seen_next;
      total         <= total_next;
    end
  end

endmodule

### sv/base64_decoder_stream.sv
// Top level of the base64 stream decoder: config register, decode core and output skid buffer.
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall   in_char
//  out       output     out_valid / out_stall data_byte, is_end, byte_count, bad_char
//  cfg       input      cfg_valid / cfg_ready alt_pad_char
//
// One character is taken per cycle while in_stall is low; a decoded byte or end item is registered
// in the output register, or in the skid entry while the output register is held.
// rst (synchronous) returns to the start of a message and loads '$' as the alternate pad.
// A two-entry output buffer (register plus skid) lets input flow while an item waits;
// in_stall rises only when both entries are held.
module base64_decoder_stream #(
  parameter int unsigned COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            in_char,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [7:0]                            data_byte,
  output logic                                  is_end,
  output logic [b64d_pkg::BYTE_COUNT_WIDTH-1:0] byte_count,
  output logic                                  bad_char,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [7:0]                            alt_pad_char
);

  logic                   cfg_write;
  logic [7:0]             alt_pad;
  logic                   take;
  logic                   has_result;
  b64d_pkg::b64d_result_t core_result;
  b64d_pkg::b64d_result_t out_item;
  b64d_pkg::b64d_result_t skid_item;
  logic                   skid_valid;
  logic                   out_take;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alt_pad <= b64d_pkg::ALT_PAD_DEFAULT;
    end else if (cfg_write) begin
      alt_pad <= alt_pad_char;
    end
  end

  assign in_stall = skid_valid;
  assign take     = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  b64d_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_char   (in_char),
    .alt_pad   (alt_pad),
    .has_result(has_result),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_item   <= skid_item;
        skid_valid <= 1'b0;
      end
    end else if (take && has_result) begin
      if (!out_valid || out_take) begin
        out_item  <= core_result;
        out_valid <= 1'b1;
      end else begin
        skid_item  <= core_result;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  assign data_byte  = out_item.data_byte;
  assign is_end     = out_item.is_end;
  assign byte_count = out_item.byte_count;
  assign bad_char   = out_item.bad_char;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_end_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_end) |-> (data_byte == 8'd0))
    else $error("end item carries a data byte");

  a_data_no_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_end) |-> (byte_count == '0))
    else $error("data item carries a byte count");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_stall) |=> skid_valid)
    else $error("skid entry lost while output stalled");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the streaming base64 decoder: scoreboard, drivers and monitor.
`timescale 1ns / 1ps

module tb_top;

  typedef enum logic [2:0] {
    POS_FIRST, POS_AFTER_GROUP, POS_AFTER_CR, POS_SECOND, POS_THIRD, POS_FOURTH
  } group_pos_t;

  // Expected decoder output, built from the characters the block accepted.
  class b64_scoreboard;
    logic [7:0]                       alt_pad;
    group_pos_t                       pos;
    logic [7:0]                       val1, val2, val3;
    logic                             third_pad;
    logic                             msg_bad;
    logic [15:0]                      msg_total;
    b64d_pkg::b64d_result_t           expected_q[$];
    int                               errors;
    int                               checked;
    int                               ends_seen;
    int                               max_count;

    function new();
      alt_pad   = b64d_pkg::ALT_PAD_DEFAULT;
      errors    = 0;
      checked   = 0;
      ends_seen = 0;
      max_count = 0;
      clear_msg();
    endfunction

    function void clear_msg();
      pos       = POS_FIRST;
      val1      = 8'h00;
      val2      = 8'h00;
      val3      = 8'h00;
      third_pad = 1'b0;
      msg_bad   = 1'b0;
      msg_total = 16'h0000;
    endfunction

    function logic [7:0] sym_val(logic [7:0] c);
      if (c >= "A" && c <= "Z") return c - "A";
      if (c >= "a" && c <= "z") return c - "a" + 8'd26;
      if (c >= "0" && c <= "9") return c - "0" + 8'd52;
      if (c == "+") return 8'd62;
      if (c == "/") return 8'd63;
      return b64d_pkg::BAD_VALUE;
    endfunction

    function logic is_pad(logic [7:0] c);
      return (c == b64d_pkg::CHAR_PAD) || (c == alt_pad);
    endfunction

    function void push_byte(logic [7:0] b, logic bad);
      b64d_pkg::b64d_result_t r;
      if (msg_total != 16'hFFFF) msg_total++;
      if (bad) msg_bad = 1'b1;
      r.data_byte  = b;
      r.is_end     = 1'b0;
      r.byte_count = '0;
      r.bad_char   = bad;
      expected_q.push_back(r);
    endfunction

    // Note one accepted character and queue the item it produces, if any.
    function void note_char(logic [7:0] c);
      b64d_pkg::b64d_result_t r;
      logic [7:0]             v4;
      case (pos)
        POS_SECOND: begin
          val2 = sym_val(c);
          pos  = POS_THIRD;
          push_byte({val1[5:0], 2'b00} | {6'b0, val2[5:4]},
                    val1 == b64d_pkg::BAD_VALUE || val2 == b64d_pkg::BAD_VALUE);
        end
        POS_THIRD: begin
          pos = POS_FOURTH;
          if (is_pad(c)) begin
            third_pad = 1'b1;
          end else begin
            third_pad = 1'b0;
            val3 = sym_val(c);
            push_byte({val2[3:0], val3[5:2]},
                      val2 == b64d_pkg::BAD_VALUE || val3 == b64d_pkg::BAD_VALUE);
          end
        end
        POS_FOURTH: begin
          pos = POS_AFTER_GROUP;
          if (!third_pad && !is_pad(c)) begin
            v4 = sym_val(c);
            push_byte({val3[1:0], 6'b0} | v4,
                      val3 == b64d_pkg::BAD_VALUE || v4 == b64d_pkg::BAD_VALUE);
          end
        end
        default: begin
          if (pos == POS_AFTER_GROUP && c == b64d_pkg::CHAR_CR) begin
            pos = POS_AFTER_CR;
          end else if (pos == POS_AFTER_CR && c == b64d_pkg::CHAR_LF) begin
            pos = POS_FIRST;
          end else if (c == b64d_pkg::CHAR_NUL) begin
            r.data_byte  = 8'h00;
            r.is_end     = 1'b1;
            r.byte_count = msg_total;
            r.bad_char   = msg_bad;
            expected_q.push_back(r);
            clear_msg();
          end else begin
            val1 = sym_val(c);
            pos  = POS_SECOND;
          end
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check(b64d_pkg::b64d_result_t got);
      b64d_pkg::b64d_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected item byte=%02h end=%0b", got.data_byte, got.is_end));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.data_byte != want.data_byte)
        report($sformatf("data_byte %02h, want %02h", got.data_byte, want.data_byte));
      if (got.is_end != want.is_end)
        report($sformatf("is_end %0b, want %0b", got.is_end, want.is_end));
      if (got.byte_count != want.byte_count)
        report($sformatf("byte_count %0d, want %0d", got.byte_count, want.byte_count));
      if (got.bad_char != want.bad_char)
        report($sformatf("bad_char %0b, want %0b", got.bad_char, want.bad_char));
      if (want.is_end) begin
        ends_seen++;
        if (want.byte_count > max_count) max_count = want.byte_count;
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  data_byte;
  logic        is_end;
  logic [b64d_pkg::BYTE_COUNT_WIDTH-1:0] byte_count;
  logic        bad_char;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  alt_pad_char;

  b64_scoreboard sb = new();
  logic          calm = 1'b0;     // no gaps on either side while set
  int            chars_sent = 0;
  int            stall_left = 0;

  base64_decoder_stream dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char      (in_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .is_end       (is_end),
    .byte_count   (byte_count),
    .bad_char     (bad_char),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .alt_pad_char (alt_pad_char)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function logic [7:0] pick_symbol();
    int idx;
    idx = $urandom_range(0, 63);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    return (idx == 62) ? 8'("+") : 8'("/");
  endfunction

  function logic [7:0] pick_pad();
    return $urandom_range(0, 1) ? b64d_pkg::CHAR_PAD : sb.alt_pad;
  endfunction

  // Output side: check every accepted item, then decide the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check('{data_byte: data_byte, is_end: is_end, byte_count: byte_count,
                 bad_char: bad_char});
    if (rst || calm) stall_left = 0;
    else if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  task send_char(input logic [7:0] c);
    int gap;
    in_char  <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_char(c);
    chars_sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every queued item has come out and the pipe is empty.
  task wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task write_pad(input logic [7:0] v);
    cfg_valid    <= 1'b1;
    alt_pad_char <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.alt_pad = v;
    cfg_valid <= 1'b0;
  endtask

  task send_message(input int groups);
    logic [7:0] grp[4];
    int         r;
    for (int g = 0; g < groups; g++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        foreach (grp[i]) grp[i] = 8'($urandom_range(0, 255));
      end else begin
        foreach (grp[i]) grp[i] = pick_symbol();
        if ((g == groups - 1 && r < 60) || r > 94) begin
          grp[3] = pick_pad();
          if ($urandom_range(0, 1)) grp[2] = pick_pad();
        end
        if ($urandom_range(0, 19) == 0)
          grp[2'($urandom_range(0, 3))] = 8'($urandom_range(0, 255));
      end
      foreach (grp[i]) send_char(grp[i]);
      r = $urandom_range(0, 99);
      if (r < 20) begin
        send_char(b64d_pkg::CHAR_CR);
        send_char(b64d_pkg::CHAR_LF);
      end else if (r < 30) begin
        send_char(b64d_pkg::CHAR_CR);
      end else if (r < 35) begin
        send_char(b64d_pkg::CHAR_LF);
      end else if (r < 40) begin
        send_char(b64d_pkg::CHAR_CR);
        send_char(b64d_pkg::CHAR_CR);
      end
    end
    if ($urandom_range(0, 19) != 0) send_char(b64d_pkg::CHAR_NUL);
  endtask

  initial begin
    logic [7:0] directed[];
    logic [7:0] pad_plan[];
    int start;
    directed = '{
      b64d_pkg::CHAR_NUL, "T", "W", "F", "u", b64d_pkg::CHAR_CR, b64d_pkg::CHAR_LF,
      "/", "+", "9", "z", b64d_pkg::CHAR_CR, "Q", "Q", "=", "=", b64d_pkg::CHAR_LF,
      8'hFF, b64d_pkg::CHAR_CR, b64d_pkg::CHAR_NUL, b64d_pkg::CHAR_CR, b64d_pkg::CHAR_CR,
      "A", "$", "x", b64d_pkg::CHAR_NUL
    };
    pad_plan = '{8'h00, 8'hFF, "A", b64d_pkg::CHAR_CR, 8'h00, b64d_pkg::ALT_PAD_DEFAULT};
    pad_plan[4] = 8'($urandom_range(1, 254));
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_char      <= 8'h00;
    cfg_valid    <= 1'b0;
    alt_pad_char <= b64d_pkg::ALT_PAD_DEFAULT;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Line breaks, pads, bad symbols, zero inside a group, empty message.
    foreach (directed[i]) send_char(directed[i]);

    foreach (pad_plan[p]) begin
      wait_idle();
      write_pad(pad_plan[p]);
      start = chars_sent;
      while (chars_sent - start < 280) begin
        calm = ($urandom_range(0, 4) == 0);
        send_message($urandom_range(1, 8));
      end
      calm = 1'b0;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d items never came out", sb.expected_q.size()));
    $display("Sent %0d characters over %0d pad settings; checked %0d items.",
             chars_sent, pad_plan.size() + 1, sb.checked);
    $display("Messages ended: %0d, largest byte count %0d, errors %0d.",
             sb.ends_seen, sb.max_count, sb.errors);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
